[sv/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; uer_cell and the top level import this package.
`default_nettype none
package uer_pkg;

  localparam int unsigned DIST_W = 10;
  localparam int unsigned TRIG_W = 16;
  localparam int unsigned TPC_W  = 16;
  localparam int unsigned PCNT_W = 4;
  localparam int unsigned GAP_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [TRIG_W-1:0] TRIG_RESET = 16'd1600;
  localparam logic [TPC_W-1:0]  TPC_RESET  = 16'd2320;
  localparam logic [DIST_W-1:0] MAXR_RESET = 10'd400;
  localparam logic [PCNT_W-1:0] PCNT_RESET = 4'd5;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 24'd4000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_TICKS = 3'd0,
    REG_TICKS_PER_CM  = 3'd1,
    REG_MAX_RANGE_CM  = 3'd2,
    REG_PING_COUNT    = 3'd3,
    REG_GAP_TICKS     = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_TIME = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_e;

  // What one sorting cell tells its right-hand neighbor.
  typedef struct packed {
    logic              le;     // cell holds a value not above the inserted one
    logic              valid;
    logic [DIST_W-1:0] value;
  } cell_link_t;

endpackage
`default_nettype wire

[sv/uer_in_if.sv]
// Input channel: one timer tick word with start request and echo level.
// No dependencies.
`default_nettype none
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;
  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface
`default_nettype wire

[sv/uer_out_if.sv]
// Output channel: one status word per accepted tick.
// No dependencies.
`default_nettype none
interface uer_out_if;
  logic       valid;
  logic       ready;
  logic       trig_level;
  logic       busy_res;
  logic       done_res;
  logic [9:0] distance_cm;
  modport source (output valid, output trig_level, output busy_res, output done_res,
                  output distance_cm, input ready);
  modport sink   (input valid, input trig_level, input busy_res, input done_res,
                  input distance_cm, output ready);
endinterface
`default_nettype wire

[sv/uer_cfg_if.sv]
// Configuration write channel: register index and write data.
// No dependencies.
`default_nettype none
interface uer_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/uer_cell.sv]
// One cell of the insertion-sorting chain holding ping distances.
// Depends on uer_pkg.
`default_nettype none
module uer_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      insert_i,
  input  logic [uer_pkg::DIST_W-1:0] new_i,
  input  uer_pkg::cell_link_t       prev_i,
  output uer_pkg::cell_link_t       link_o
);
  import uer_pkg::*;

  logic              valid_q, valid_d;
  logic [DIST_W-1:0] value_q, value_d;
  logic              le;

  assign le = valid_q && (value_q <= new_i);

  // A cell keeps its value when it is not above the new one; otherwise it
  // takes the new value or shifts in its left neighbor's.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (insert_i && !le) begin
      if (prev_i.le) begin
        value_d = new_i;
        valid_d = 1'b1;
      end else begin
        value_d = prev_i.value;
        valid_d = prev_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o = '{le: le, valid: valid_q, value: value_q};
endmodule
`default_nettype wire

[sv/ultrasonic_echo_ranger_median.sv]
// Top level of the ultrasonic echo ranger with median filter.
// Depends on uer_pkg, uer_in_if, uer_out_if, uer_cfg_if and uer_cell.
//
//   channel | role | word contents
//   in_i    | sink | start_req, echo_level (one timer tick)
//   out_o   | src  | trig_level, busy_res, done_res, distance_cm
//   cfg_i   | sink | index, data (register write, always ready)
//
// A tick word is accepted whenever the output register is empty or being
// emptied, so one word per cycle flows through while the output is not stalled.
// Each accepted tick yields exactly one status word in the output register.
// A stalled output holds the status word and stops input acceptance.
// Reset returns to idle with the register defaults and an empty sort chain.
// The median needs no sort pass: each ping's distance is inserted into a
// sorted chain of cells as it is measured, and the done tick reads one cell.
`default_nettype none
module ultrasonic_echo_ranger_median #(
  parameter int unsigned MAX_PINGS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uer_in_if.sink    in_i,
  uer_out_if.source out_o,
  uer_cfg_if.sink   cfg_i
);
  import uer_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_PINGS + 1);
  localparam int unsigned NW  = (IW > PCNT_W) ? IW : PCNT_W;
  localparam logic [NW-1:0] MAXN = NW'(MAX_PINGS);

  // Configuration registers.
  logic [TRIG_W-1:0] trig_ticks_q;
  logic [TPC_W-1:0]  tpc_q;
  logic [DIST_W-1:0] max_range_q;
  logic [PCNT_W-1:0] ping_count_q;
  logic [GAP_W-1:0]  gap_ticks_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIG_RESET;
      tpc_q        <= TPC_RESET;
      max_range_q  <= MAXR_RESET;
      ping_count_q <= PCNT_RESET;
      gap_ticks_q  <= GAP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_TRIGGER_TICKS: trig_ticks_q <= cfg_i.data[TRIG_W-1:0];
        REG_TICKS_PER_CM:  tpc_q        <= cfg_i.data[TPC_W-1:0];
        REG_MAX_RANGE_CM:  max_range_q  <= cfg_i.data[DIST_W-1:0];
        REG_PING_COUNT:    ping_count_q <= cfg_i.data[PCNT_W-1:0];
        REG_GAP_TICKS:     gap_ticks_q  <= cfg_i.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  phase_e            phase_q, phase_d;
  logic [GAP_W-1:0]  tick_q, tick_d;
  logic [TPC_W-1:0]  sub_q, sub_d;
  logic [DIST_W-1:0] cm_q, cm_d;
  logic [IW-1:0]     ping_q, ping_d;
  logic [DIST_W-1:0] median_q, median_d;
  logic              done;
  logic              clear_chain, insert;

  // Output register.
  logic              out_valid_q;
  logic              trig_q, busy_q, done_q;

  logic in_fire;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Pings wanted, clamped to one through MAX_PINGS.
  logic [NW-1:0] n_raw, n_want;
  logic [IW-1:0] k_sel;
  assign n_raw  = NW'(ping_count_q);
  assign n_want = (n_raw == '0) ? NW'(1) : ((n_raw > MAXN) ? MAXN : n_raw);
  assign k_sel  = IW'(n_want >> 1);

  // Sorting chain: cell 0 sits leftmost and holds the smallest distance.
  // The chain must only move on accepted ticks.
  cell_link_t link [MAX_PINGS+1];
  assign link[0] = '{le: 1'b1, valid: 1'b1, value: '0};

  for (genvar g = 0; g < MAX_PINGS; g++) begin : g_cell
    uer_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (clear_chain && in_fire),
      .insert_i (insert && in_fire),
      .new_i    (cm_q),
      .prev_i   (link[g]),
      .link_o   (link[g+1])
    );
  end

  logic [DIST_W-1:0] median_pick;
  always_comb begin
    median_pick = '0;
    for (int i = 0; i < MAX_PINGS; i++) begin
      if (k_sel == IW'(i)) median_pick = link[i+1].value;
    end
  end

  logic [TPC_W:0] sub_inc;
  logic [IW-1:0]  ping_inc;
  assign sub_inc  = {1'b0, sub_q} + 1'b1;
  assign ping_inc = ping_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    sub_d       = sub_q;
    cm_d        = cm_q;
    ping_d      = ping_q;
    median_d    = median_q;
    done        = 1'b0;
    clear_chain = 1'b0;
    insert      = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          phase_d     = PH_TRIG;
          tick_d      = GAP_W'(1);
          ping_d      = '0;
          clear_chain = 1'b1;
        end
      end
      PH_TRIG: begin
        if (tick_q >= GAP_W'(trig_ticks_q)) begin
          phase_d = PH_WAIT;
        end else begin
          tick_d = tick_q + 1'b1;
        end
      end
      PH_WAIT: begin
        if (in_i.echo_level) begin
          phase_d = PH_TIME;
          sub_d   = '0;
          cm_d    = '0;
        end
      end
      PH_TIME: begin
        if (in_i.echo_level && (cm_q < max_range_q)) begin
          if (sub_inc >= {1'b0, tpc_q}) begin
            sub_d = '0;
            cm_d  = cm_q + 1'b1;
          end else begin
            sub_d = sub_inc[TPC_W-1:0];
          end
        end else begin
          insert  = (NW'(ping_q) < MAXN);
          phase_d = PH_GAP;
          tick_d  = '0;
        end
      end
      PH_GAP: begin
        if (tick_q >= gap_ticks_q) begin
          if (NW'(ping_inc) >= n_want) begin
            median_d = median_pick;
            phase_d  = PH_IDLE;
            ping_d   = '0;
            done     = 1'b1;
          end else begin
            ping_d  = ping_inc;
            phase_d = PH_TRIG;
            tick_d  = GAP_W'(1);
          end
        end else begin
          tick_d = tick_q + 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      sub_q       <= '0;
      cm_q        <= '0;
      ping_q      <= '0;
      median_q    <= '0;
      out_valid_q <= 1'b0;
      trig_q      <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        sub_q       <= sub_d;
        cm_q        <= cm_d;
        ping_q      <= ping_d;
        median_q    <= median_d;
        out_valid_q <= 1'b1;
        trig_q      <= (phase_d == PH_TRIG);
        busy_q      <= (phase_d != PH_IDLE);
        done_q      <= done;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.trig_level  = trig_q;
  assign out_o.busy_res    = busy_q;
  assign out_o.done_res    = done_q;
  assign out_o.distance_cm = median_q;
endmodule
`default_nettype wire
